[rtl/dtmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared types, gains and the sine table builder for the DTMF tone sender.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  // Command from the front end to the back end.
  typedef struct packed {
    logic       kind;   // 1 = push, 0 = sample tick
    logic       ok;     // push code is a DTMF character
    logic [3:0] digit;  // row*4 + column
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic              accepted;
    logic              busy;
    logic              tone_on;
    logic signed [15:0] sample;
  } res_t;

  localparam logic KindTick = 1'b0;
  localparam logic KindPush = 1'b1;

  localparam logic [0:0] RegOnSamples  = 1'b0;
  localparam logic [0:0] RegOffSamples = 1'b1;

  localparam logic signed [15:0] RowGain = 16'sd10813;  // 0.33 in Q15
  localparam logic signed [15:0] ColGain = 16'sd13613;  // 0.33 * twist

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // ASCII to digit index; ok is low for anything that is not a DTMF key.
  function automatic cmd_t classify(input logic kind, input logic [7:0] code);
    cmd_t c;
    c.kind  = kind;
    c.ok    = 1'b1;
    c.digit = 4'd0;
    case (code)
      "1":      c.digit = 4'd0;
      "2":      c.digit = 4'd1;
      "3":      c.digit = 4'd2;
      "A", "a": c.digit = 4'd3;
      "4":      c.digit = 4'd4;
      "5":      c.digit = 4'd5;
      "6":      c.digit = 4'd6;
      "B", "b": c.digit = 4'd7;
      "7":      c.digit = 4'd8;
      "8":      c.digit = 4'd9;
      "9":      c.digit = 4'd10;
      "C", "c": c.digit = 4'd11;
      "*":      c.digit = 4'd12;
      "0":      c.digit = 4'd13;
      "#":      c.digit = 4'd14;
      "D", "d": c.digit = 4'd15;
      default:  c.ok = 1'b0;
    endcase
    return c;
  endfunction

  // Q2.30 sine entry i of a 2**lg point table, quadrant folded Taylor series.
  // Evaluated only at elaboration.
  function automatic logic signed [31:0] sine_entry(input int unsigned i,
                                                   input int unsigned lg);
    longint unsigned t, r, x, x2, term, prod;
    longint          sum;
    int unsigned     quad;
    t    = longint'(i) << (32 - lg);
    quad = int'((t >> 30) & 64'd3);
    r    = t & 64'h3FFF_FFFF;
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HalfPiQ30) >> 30;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = x;
    for (int k = 1; k <= 6; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1:       term = prod / 6;
        2:       term = prod / 20;
        3:       term = prod / 42;
        4:       term = prod / 72;
        5:       term = prod / 110;
        default: term = prod / 156;
      endcase
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sh4000_0000) sum = 64'sh4000_0000;
    return (quad >= 2) ? 32'(-sum) : 32'(sum);
  endfunction

endpackage

[rtl/dtmf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_front
// Accepts input transactions, classifies the key code, two-entry command queue.
// ----------------------------------------------------------------------------
module dtmf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [7:0]           code_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output dtmf_pkg::cmd_t       cmd_o
);

  dtmf_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;
  logic           push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dtmf_pkg::classify(kind_i, code_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

[rtl/dtmf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_back
// Digit queue, interval timing and the two-tone DDS datapath with output reg.
// ----------------------------------------------------------------------------
module dtmf_back #(
  parameter int unsigned AUDIO_RATE  = 8000,
  parameter int unsigned SINE_POINTS = 1024,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [19:0]          tone_len_i,
  input  logic [19:0]          gap_len_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  dtmf_pkg::cmd_t       cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output dtmf_pkg::res_t       res_o
);

  localparam int unsigned Lg    = $clog2(SINE_POINTS);
  localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FracSh = 16 - Lg;

  localparam logic [63:0] Half = 64'(AUDIO_RATE / 2);
  localparam logic [63:0] Rate = 64'(AUDIO_RATE);
  localparam logic [31:0] RowInc [4] = '{
    32'(((64'd697  << 32) + Half) / Rate), 32'(((64'd770  << 32) + Half) / Rate),
    32'(((64'd852  << 32) + Half) / Rate), 32'(((64'd941  << 32) + Half) / Rate)};
  localparam logic [31:0] ColInc [4] = '{
    32'(((64'd1209 << 32) + Half) / Rate), 32'(((64'd1336 << 32) + Half) / Rate),
    32'(((64'd1477 << 32) + Half) / Rate), 32'(((64'd1633 << 32) + Half) / Rate)};

  typedef logic signed [31:0] rom_t [SINE_POINTS];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < SINE_POINTS; i++) begin
      r[i] = dtmf_pkg::sine_entry(i, Lg);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_R0   = 4'd1;
  localparam logic [3:0] S_R1   = 4'd2;
  localparam logic [3:0] S_R2   = 4'd3;
  localparam logic [3:0] S_R3   = 4'd4;
  localparam logic [3:0] S_R4   = 4'd5;
  localparam logic [3:0] S_R5   = 4'd6;
  localparam logic [3:0] S_R6   = 4'd7;
  localparam logic [3:0] S_LD0  = 4'd8;
  localparam logic [3:0] S_LD1  = 4'd9;

  logic [3:0]          state_q;
  logic [3:0]          queue_mem [QUEUE_DEPTH];
  logic [3:0]          qrd_q;
  logic [QW-1:0]       head_q;
  logic [CW-1:0]       count_q;
  logic [3:0]          cur_q;
  logic [31:0]         row_ph_q, col_ph_q;
  logic [19:0]         cnt_q;
  logic                in_tone_q;
  logic                out_valid_q;
  dtmf_pkg::res_t      out_q;

  logic [Lg-1:0]       idx_r, idx_c, rom_addr;
  logic [15:0]         frac_r, frac_c;
  logic signed [31:0]  rom_q, ra_q, ca_q;
  logic signed [49:0]  prod_q;
  logic signed [33:0]  rt_q, ct;
  logic signed [50:0]  acc_q, acc_rnd;
  logic signed [20:0]  shifted;
  logic signed [15:0]  sat;
  logic [19:0]         cnt_inc;
  logic [QW:0]         wr_sum;
  logic [QW-1:0]       wr_ptr, head_nx;
  logic                take;

  assign cmd_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign take        = cmd_valid_i & cmd_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign idx_r  = row_ph_q[31 -: Lg];
  assign idx_c  = col_ph_q[31 -: Lg];
  assign frac_r = 16'(row_ph_q >> FracSh);
  assign frac_c = 16'(col_ph_q >> FracSh);

  always_comb begin
    case (state_q)
      S_R1:    rom_addr = idx_r + 1'b1;
      S_R2:    rom_addr = idx_c;
      S_R3:    rom_addr = idx_c + 1'b1;
      default: rom_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[rom_addr];
  end

  assign wr_sum  = (QW + 1)'(head_q) + (QW + 1)'(count_q);
  assign wr_ptr  = (wr_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                   QW'(wr_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(wr_sum);
  assign head_nx = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign cnt_inc = cnt_q + 20'd1;

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.kind == dtmf_pkg::KindPush && cmd_i.ok &&
        count_q < CW'(QUEUE_DEPTH)) begin
      queue_mem[wr_ptr] <= cmd_i.digit;
    end
    qrd_q <= queue_mem[head_q];
  end

  // Datapath: interpolate row then column tone, scale by gains, sum.
  assign ct      = 34'(ca_q) + 34'(prod_q >>> 16);
  assign acc_rnd = acc_q + 51'sd536870912;
  assign shifted = 21'(acc_rnd >>> 30);
  assign sat     = (shifted > 21'sd32767)  ? 16'sh7FFF :
                   (shifted < -21'sd32768) ? 16'sh8000 : 16'(shifted);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_R1: ra_q <= rom_q;
      S_R2: prod_q <= ($signed({rom_q[31], rom_q}) - $signed({ra_q[31], ra_q})) *
                      $signed({1'b0, frac_r});
      S_R3: begin
        ca_q <= rom_q;
        rt_q <= 34'(ra_q) + 34'(prod_q >>> 16);
      end
      S_R4: begin
        prod_q <= ($signed({rom_q[31], rom_q}) - $signed({ca_q[31], ca_q})) *
                  $signed({1'b0, frac_c});
        acc_q  <= 51'(rt_q) * 51'(dtmf_pkg::RowGain);
      end
      S_R5: acc_q <= acc_q + 51'(ct) * 51'(dtmf_pkg::ColGain);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      row_ph_q    <= '0;
      col_ph_q    <= '0;
      cnt_q       <= '0;
      in_tone_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && res_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (cmd_i.kind == dtmf_pkg::KindPush) begin
              out_valid_q    <= 1'b1;
              out_q.sample   <= '0;
              if (cmd_i.ok && count_q < CW'(QUEUE_DEPTH)) begin
                count_q        <= count_q + 1'b1;
                out_q.accepted <= 1'b1;
                out_q.busy     <= 1'b1;
                if (count_q == '0) begin
                  cur_q     <= cmd_i.digit;
                  row_ph_q  <= '0;
                  col_ph_q  <= '0;
                  cnt_q     <= '0;
                  in_tone_q <= 1'b1;
                  out_q.tone_on <= 1'b1;
                end else begin
                  out_q.tone_on <= in_tone_q;
                end
              end else begin
                out_q.accepted <= 1'b0;
                out_q.busy     <= (count_q != '0);
                out_q.tone_on  <= in_tone_q && (count_q != '0);
              end
            end else if (count_q == '0) begin
              out_valid_q <= 1'b1;
              out_q       <= '0;
            end else if (in_tone_q) begin
              state_q <= S_R0;
            end else begin
              out_valid_q    <= 1'b1;
              out_q.sample   <= '0;
              out_q.tone_on  <= 1'b0;
              out_q.accepted <= 1'b0;
              if (cnt_inc >= gap_len_i) begin
                cnt_q   <= '0;
                head_q  <= head_nx;
                count_q <= count_q - 1'b1;
                out_q.busy <= (count_q != CW'(1));
                if (count_q != CW'(1)) state_q <= S_LD0;
              end else begin
                cnt_q      <= cnt_inc;
                out_q.busy <= 1'b1;
              end
            end
          end
        end
        S_R0: state_q <= S_R1;
        S_R1: state_q <= S_R2;
        S_R2: state_q <= S_R3;
        S_R3: state_q <= S_R4;
        S_R4: state_q <= S_R5;
        S_R5: state_q <= S_R6;
        S_R6: begin
          out_valid_q    <= 1'b1;
          out_q.sample   <= sat;
          out_q.tone_on  <= 1'b1;
          out_q.busy     <= 1'b1;
          out_q.accepted <= 1'b0;
          row_ph_q <= row_ph_q + RowInc[cur_q[3:2]];
          col_ph_q <= col_ph_q + ColInc[cur_q[1:0]];
          if (cnt_inc >= tone_len_i) begin
            cnt_q     <= '0;
            in_tone_q <= 1'b0;
          end else begin
            cnt_q <= cnt_inc;
          end
          state_q <= S_IDLE;
        end
        S_LD0: state_q <= S_LD1;
        S_LD1: begin
          cur_q     <= qrd_q;
          row_ph_q  <= '0;
          col_ph_q  <= '0;
          cnt_q     <= '0;
          in_tone_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/dtmf_digit_tone_sender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_digit_tone_sender
// Queues DTMF key codes and renders them as two-tone Q1.15 audio per tick.
// ----------------------------------------------------------------------------
// A push transaction (tuser = 1) carries an ASCII key (0-9 * # A-D a-d); valid
// keys are queued up to QUEUE_DEPTH deep, others are refused. Every tick
// transaction (tuser = 0) returns one sample: the row and column tones summed
// for the tone length (register 0) in ticks, then the gap length (register 1)
// in ticks of silence, then the next key starts with both phases at zero. Each
// input gives exactly one output. A sounding tick runs through the states S_R0
// to S_R6, set by the four sequential reads of the single-port sine ROM and
// the multiply steps; the tick that ends a gap and starts a new key also passes
// through S_LD0 and S_LD1 for the queue memory read. A two-entry command queue
// lets input keep arriving while a result waits on the output.
// ----------------------------------------------------------------------------
module dtmf_digit_tone_sender #(
  parameter int unsigned AUDIO_RATE  = 8000,
  parameter int unsigned SINE_POINTS = 1024,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] digit_code
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] sample, [16] tone_on,
                                      // [17] busy_res, [18] digit_accepted
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);

  logic [19:0]    on_q, off_q;
  logic           cmd_valid, cmd_ready;
  dtmf_pkg::cmd_t cmd;
  dtmf_pkg::res_t res;

  // Interval length registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q  <= 20'd640;
      off_q <= 20'd640;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtmf_pkg::RegOnSamples:  on_q  <= cfg_wdata_i;
        dtmf_pkg::RegOffSamples: off_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dtmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser[0]),
    .code_i      (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  dtmf_back #(
    .AUDIO_RATE  (AUDIO_RATE),
    .SINE_POINTS (SINE_POINTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tone_len_i  (on_q),
    .gap_len_i   (off_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.accepted, res.busy, res.tone_on, res.sample};

`ifndef NO_ASSERTIONS
  // An accepted key always leaves the sender busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.accepted |-> res.busy)
    else $error("accepted key without busy");

  // A sounding tone implies queued work.
  a_tone_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.tone_on |-> res.busy)
    else $error("tone_on without busy");

  // Only a tone interval produces non-zero audio.
  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.tone_on |-> res.sample == 16'sd0)
    else $error("audio outside tone interval");
`endif

endmodule
